[hdl/pfd_pkg.sv]
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, constants and saturation helpers for the fluid drag pipeline.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    typedef enum logic [2:0] {
        REG_LINEAR_COEFF    = 3'd0,
        REG_QUADRATIC_COEFF = 3'd1,
        REG_RADIUS_OVERRIDE = 3'd2,
        REG_WIND_X          = 3'd3,
        REG_WIND_Y          = 3'd4,
        REG_WIND_Z          = 3'd5
    } pfd_reg_t;

    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [30:0]      radius;
        logic [30:0]      minv;
        logic [30:0]      dt;
    } pfd_side_t;

    function automatic logic [30:0] sat31(input logic [63:0] v);
        logic [30:0] r;
        r = (v > 64'h0000_0000_7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
        return r;
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[hdl/pfd_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// pfd_sqrt_pipe
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pfd_sqrt_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [63:0]         sum,
    input  pfd_pkg::pfd_side_t  in_side,
    output logic                out_vld,
    output logic [31:0]         root,
    output pfd_pkg::pfd_side_t  out_side
);
    import pfd_pkg::*;

    logic [63:0] n_reg   [1:SQRT_STAGES];
    logic [63:0] res_reg [1:SQRT_STAGES];
    pfd_side_t   side_reg[1:SQRT_STAGES];
    logic        vld_reg [1:SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_cur;
        logic [63:0] res_cur;
        pfd_side_t   side_cur;
        logic        vld_cur;
        logic [63:0] trial;
        logic        ge;

        if (k == 0) begin : g_head
            assign n_cur    = sum;
            assign res_cur  = 64'd0;
            assign side_cur = in_side;
            assign vld_cur  = in_vld;
        end
        else begin : g_body
            assign n_cur    = n_reg[k];
            assign res_cur  = res_reg[k];
            assign side_cur = side_reg[k];
            assign vld_cur  = vld_reg[k];
        end

        assign trial = res_cur + BIT;
        assign ge    = n_cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k+1]    <= ge ? n_cur - trial : n_cur;
                res_reg[k+1]  <= ge ? (res_cur >> 1) + BIT : res_cur >> 1;
                side_reg[k+1] <= side_cur;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STAGES];
    assign root     = res_reg[SQRT_STAGES][31:0];
    assign out_side = side_reg[SQRT_STAGES];

endmodule

[hdl/pfd_drag_calc.sv]
// ----------------------------------------------------------------------------
// pfd_drag_calc
// Drag magnitude chain: radius-speed, linear and quadratic terms, impulse
// scaling by inverse mass and time step, clamp, and per-axis numerators.
// ----------------------------------------------------------------------------
module pfd_drag_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [30:0]         linear_coeff,
    input  logic [30:0]         quadratic_coeff,
    input  logic                in_vld,
    input  logic [31:0]         vm,
    input  pfd_pkg::pfd_side_t  in_side,
    output logic                out_vld,
    output logic [31:0]         out_vm,
    output logic [2:0][63:0]    num,
    output pfd_pkg::pfd_side_t  out_side
);
    import pfd_pkg::*;

    localparam int NS = 7;

    logic        vld_reg  [1:NS];
    pfd_side_t   side_reg [1:NS];
    logic [31:0] vm_reg   [1:NS];

    logic [30:0] rv_reg;
    logic [30:0] lin_reg;
    logic [30:0] lin2_reg;
    logic [30:0] rv2_reg;
    logic [30:0] quad_reg;
    logic [30:0] drag_reg;
    logic [30:0] t_reg;
    logic [30:0] k_reg;
    logic [2:0][63:0] num_reg;

    logic [31:0] m_next;

    assign m_next = ({1'b0, k_reg} < vm_reg[6]) ? {1'b0, k_reg} : vm_reg[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NS; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_vld;
            for (int s = 2; s <= NS; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= in_side;
            vm_reg[1]   <= vm;
            for (int s = 2; s <= NS; s++)
            begin
                side_reg[s] <= side_reg[s-1];
                vm_reg[s]   <= vm_reg[s-1];
            end
            rv_reg   <= sat31(64'(in_side.radius * vm) >> 16);
            lin_reg  <= sat31(64'(linear_coeff * rv_reg) >> 16);
            rv2_reg  <= sat31(64'(rv_reg * rv_reg) >> 16);
            quad_reg <= sat31(64'(quadratic_coeff * rv2_reg) >> 16);
            lin2_reg <= lin_reg;
            drag_reg <= sat31(64'({1'b0, lin2_reg} + {1'b0, quad_reg}));
            t_reg    <= sat31(64'(drag_reg * side_reg[4].minv) >> 16);
            k_reg    <= sat31(64'(t_reg * side_reg[5].dt) >> 16);
            for (int i = 0; i < 3; i++)
                num_reg[i] <= 64'(m_next * side_reg[6].mag[i]);
        end
    end

    assign out_vld  = vld_reg[NS];
    assign out_vm   = vm_reg[NS];
    assign num      = num_reg;
    assign out_side = side_reg[NS];

endmodule

[hdl/pfd_div_pipe.sv]
// ----------------------------------------------------------------------------
// pfd_div_pipe
// Three-lane restoring divider, one quotient bit per stage, followed by the
// signed velocity update and the output register.
// ----------------------------------------------------------------------------
module pfd_div_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [31:0]         vm,
    input  logic [2:0][63:0]    num,
    input  pfd_pkg::pfd_side_t  in_side,
    output logic                out_vld,
    output logic [2:0][31:0]    new_vel
);
    import pfd_pkg::*;

    logic             vld_reg  [1:DIV_STAGES];
    logic [31:0]      vm_reg   [1:DIV_STAGES];
    logic [2:0][31:0] rem_reg  [1:DIV_STAGES];
    logic [2:0][31:0] low_reg  [1:DIV_STAGES];
    logic [2:0][31:0] q_reg    [1:DIV_STAGES];
    logic [2:0][31:0] vel_reg  [1:DIV_STAGES];
    logic [2:0]       neg_reg  [1:DIV_STAGES];

    logic             out_vld_reg;
    logic [2:0][31:0] new_vel_reg;
    logic [2:0][31:0] new_vel_next;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic             vld_cur;
        logic [31:0]      vm_cur;
        logic [2:0][31:0] rem_cur;
        logic [2:0][31:0] low_cur;
        logic [2:0][31:0] q_cur;
        logic [2:0][31:0] vel_cur;
        logic [2:0]       neg_cur;
        logic [2:0][32:0] t;
        logic [2:0]       ge;

        if (k == 0) begin : g_head
            assign vld_cur = in_vld;
            assign vm_cur  = vm;
            assign rem_cur = {num[2][63:32], num[1][63:32], num[0][63:32]};
            assign low_cur = {num[2][31:0], num[1][31:0], num[0][31:0]};
            assign q_cur   = '0;
            assign vel_cur = in_side.vel;
            assign neg_cur = in_side.neg;
        end
        else begin : g_body
            assign vld_cur = vld_reg[k];
            assign vm_cur  = vm_reg[k];
            assign rem_cur = rem_reg[k];
            assign low_cur = low_reg[k];
            assign q_cur   = q_reg[k];
            assign vel_cur = vel_reg[k];
            assign neg_cur = neg_reg[k];
        end

        for (genvar i = 0; i < 3; i++) begin : g_lane
            assign t[i]  = {rem_cur[i], low_cur[i][31]};
            assign ge[i] = t[i] >= {1'b0, vm_cur};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vm_reg[k+1]  <= vm_cur;
                vel_reg[k+1] <= vel_cur;
                neg_reg[k+1] <= neg_cur;
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k+1][i] <= ge[i] ? 32'(t[i] - {1'b0, vm_cur}) : t[i][31:0];
                    low_reg[k+1][i] <= {low_cur[i][30:0], 1'b0};
                    q_reg[k+1][i]   <= {q_cur[i][30:0], ge[i]};
                end
            end
        end
    end

    always_comb
    begin
        logic [31:0]        d;
        logic signed [33:0] dv;
        logic signed [33:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            d  = (vm_reg[DIV_STAGES] == 32'd0) ? 32'd0 : q_reg[DIV_STAGES][i];
            dv = neg_reg[DIV_STAGES][i] ? $signed({2'b00, d}) : -$signed({2'b00, d});
            sum = $signed({{2{vel_reg[DIV_STAGES][i][31]}}, vel_reg[DIV_STAGES][i]}) + dv;
            new_vel_next[i] = sat_s32(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            new_vel_reg <= new_vel_next;
    end

    assign out_vld = out_vld_reg;
    assign new_vel = new_vel_reg;

endmodule

[hdl/particle_fluid_drag_step.sv]
// ----------------------------------------------------------------------------
// particle_fluid_drag_step
// Linear plus quadratic fluid drag on one particle per transaction, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one particle: velocity, radius,
//   inverse mass and time step. Output channel (out_valid/out_ready) returns
//   the updated velocity, one result per input, in order.
//   Configuration: cfg_we writes cfg_data to the register at cfg_index at the
//   clock edge; unknown indexes are ignored. Write only while idle.
//   Pipeline: 3 front stages, 32 square-root stages, 7 drag stages, 32 divider
//   stages and an output register lie between input acceptance and out_valid.
//   Throughput: one transaction per cycle unless stalled; every stage is a register and the
//   square root and divider resolve one bit per stage.
//   Reset: clears all valid bits and configuration registers to zero.
//   Stall: when out_valid is high and out_ready low, the whole pipeline holds
//   and in_ready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module particle_fluid_drag_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    input  logic [31:0] vel_z,
    input  logic [30:0] particle_radius,
    input  logic [30:0] mass_inverse,
    input  logic [30:0] time_step,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] new_vel_x,
    output logic [31:0] new_vel_y,
    output logic [31:0] new_vel_z
);
    import pfd_pkg::*;

    logic [30:0]      linear_coeff_reg;
    logic [30:0]      quadratic_coeff_reg;
    logic [30:0]      radius_override_reg;
    logic [2:0][31:0] wind_reg;

    logic             en;
    logic [2:0][31:0] vel_in;
    pfd_side_t        f1_side_next;

    logic             f1_vld_reg;
    pfd_side_t        f1_side_reg;
    logic             f2_vld_reg;
    pfd_side_t        f2_side_reg;
    logic [2:0][63:0] sq_reg;
    logic             f3_vld_reg;
    pfd_side_t        f3_side_reg;
    logic [63:0]      sum_reg;

    logic             sq_vld;
    logic [31:0]      sq_root;
    pfd_side_t        sq_side;
    logic             dr_vld;
    logic [31:0]      dr_vm;
    logic [2:0][63:0] dr_num;
    pfd_side_t        dr_side;
    logic [2:0][31:0] new_vel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_coeff_reg    <= '0;
            quadratic_coeff_reg <= '0;
            radius_override_reg <= '0;
            wind_reg            <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINEAR_COEFF:    linear_coeff_reg    <= cfg_data[30:0];
                REG_QUADRATIC_COEFF: quadratic_coeff_reg <= cfg_data[30:0];
                REG_RADIUS_OVERRIDE: radius_override_reg <= cfg_data[30:0];
                REG_WIND_X:          wind_reg[0]         <= cfg_data;
                REG_WIND_Y:          wind_reg[1]         <= cfg_data;
                REG_WIND_Z:          wind_reg[2]         <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign vel_in   = {vel_z, vel_y, vel_x};

    always_comb
    begin
        logic [31:0] rel;
        f1_side_next.vel    = vel_in;
        f1_side_next.radius = (radius_override_reg != 31'd0) ? radius_override_reg
                                                               : particle_radius;
        f1_side_next.minv   = mass_inverse;
        f1_side_next.dt     = time_step;
        for (int i = 0; i < 3; i++)
        begin
            rel = sat_s32($signed({{2{vel_in[i][31]}}, vel_in[i]})
                        - $signed({{2{wind_reg[i][31]}}, wind_reg[i]}));
            f1_side_next.neg[i] = rel[31];
            f1_side_next.mag[i] = rel[31] ? 32'(-rel) : rel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_side_reg <= f1_side_next;
            f2_side_reg <= f1_side_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= 64'(f1_side_reg.mag[i] * f1_side_reg.mag[i]);
            f3_side_reg <= f2_side_reg;
            sum_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    pfd_sqrt_pipe u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f3_vld_reg),
        .sum      (sum_reg),
        .in_side  (f3_side_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    pfd_drag_calc u_drag (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .linear_coeff    (linear_coeff_reg),
        .quadratic_coeff (quadratic_coeff_reg),
        .in_vld          (sq_vld),
        .vm              (sq_root),
        .in_side         (sq_side),
        .out_vld         (dr_vld),
        .out_vm          (dr_vm),
        .num             (dr_num),
        .out_side        (dr_side)
    );

    pfd_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (dr_vld),
        .vm       (dr_vm),
        .num      (dr_num),
        .in_side  (dr_side),
        .out_vld  (out_valid),
        .new_vel  (new_vel)
    );

    assign new_vel_x = new_vel[0];
    assign new_vel_y = new_vel[1];
    assign new_vel_z = new_vel[2];

endmodule

[hdl/pfd_checker.sv]
// ----------------------------------------------------------------------------
// pfd_checker
// Port-level checks on the drag pipeline's handshakes and stall behavior.
// ----------------------------------------------------------------------------
module pfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] new_vel_x
);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken during output stall");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("out_valid dropped before transaction");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(new_vel_x))
        else $error("output payload changed during stall");

endmodule

bind particle_fluid_drag_step pfd_checker u_pfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_vel_x (new_vel_x)
);

[verif/tb_particle_fluid_drag_step.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_particle_fluid_drag_step
// Streams particles through the drag pipeline under several coefficient and
// wind settings, predicts each updated velocity in fixed point, and compares
// every result in order; in all tests but the last, both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_particle_fluid_drag_step;
    import pfd_pkg::*;

    localparam int PIPE_LATENCY = 80;
    localparam int STALL_LIMIT  = 20000;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } velocity_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [30:0] particle_radius;
    logic [30:0] mass_inverse;
    logic [30:0] time_step;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;

    logic [30:0] lin_coeff_q;
    logic [30:0] quad_coeff_q;
    logic [30:0] radius_ovr_q;
    logic [31:0] wind_q [3];

    velocity_t   pending_vel [$];
    int          error_count;
    int          sent_count;
    int          result_count;
    int          idle_cycles;
    bit          gaps_on;
    bit          hold_sink;

    particle_fluid_drag_step DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] clip31(input logic [127:0] v);
        return (v > 128'h7FFF_FFFF) ? 64'h7FFF_FFFF : v[63:0];
    endfunction

    function automatic longint clip_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic velocity_t drag_update(input logic [31:0] v [3],
        input logic [30:0] rad, input logic [30:0] minv, input logic [30:0] dt);
        longint      vs [3];
        longint      rs [3];
        logic [63:0] ra [3];
        logic [63:0] sum, vm, r, rv, lin, rv2, quad, drg, k, m, d, rem, bitv;
        longint      dv;
        velocity_t   res;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            vs[i] = longint'(signed'(v[i]));
            rs[i] = clip_s32(vs[i] - longint'(signed'(wind_q[i])));
            ra[i] = rs[i] < 0 ? 64'(-rs[i]) : 64'(rs[i]);
            sum += ra[i] * ra[i];
        end
        vm = 0;
        rem = sum;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= vm + bitv)
            begin
                rem -= vm + bitv;
                vm = (vm >> 1) + bitv;
            end
            else
                vm >>= 1;
            bitv >>= 2;
        end
        r    = radius_ovr_q != 0 ? 64'(radius_ovr_q) : 64'(rad);
        rv   = clip31((128'(r) * vm) >> 16);
        lin  = clip31((128'(lin_coeff_q) * rv) >> 16);
        rv2  = clip31((128'(rv) * rv) >> 16);
        quad = clip31((128'(quad_coeff_q) * rv2) >> 16);
        drg  = clip31(128'(lin) + quad);
        k    = clip31((128'(clip31((128'(drg) * minv) >> 16)) * dt) >> 16);
        m    = k < vm ? k : vm;
        for (int i = 0; i < 3; i++)
        begin
            dv = 0;
            if (vm != 0)
            begin
                d  = 64'((128'(m) * ra[i]) / vm);
                dv = rs[i] < 0 ? longint'(d) : -longint'(d);
            end
            vs[i] = clip_s32(vs[i] + dv);
        end
        res.vx = vs[0][31:0];
        res.vy = vs[1][31:0];
        res.vz = vs[2][31:0];
        return res;
    endfunction

    task automatic write_reg(input pfd_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_LINEAR_COEFF:    lin_coeff_q  = value[30:0];
            REG_QUADRATIC_COEFF: quad_coeff_q = value[30:0];
            REG_RADIUS_OVERRIDE: radius_ovr_q = value[30:0];
            REG_WIND_X:          wind_q[0]    = value;
            REG_WIND_Y:          wind_q[1]    = value;
            REG_WIND_Z:          wind_q[2]    = value;
            default: ;
        endcase
    endtask

    task automatic set_drag(input logic [31:0] a, input logic [31:0] b,
        input logic [31:0] ro, input logic [31:0] wx, input logic [31:0] wy,
        input logic [31:0] wz);
        wait (pending_vel.size() == 0);
        repeat (PIPE_LATENCY) @(negedge clk);
        write_reg(REG_LINEAR_COEFF, a);
        write_reg(REG_QUADRATIC_COEFF, b);
        write_reg(REG_RADIUS_OVERRIDE, ro);
        write_reg(REG_WIND_X, wx);
        write_reg(REG_WIND_Y, wy);
        write_reg(REG_WIND_Z, wz);
    endtask

    task automatic send_particle(input logic [31:0] vx, input logic [31:0] vy,
        input logic [31:0] vz, input logic [30:0] rad, input logic [30:0] minv,
        input logic [30:0] dt);
        logic [31:0] v [3];
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 19)) @(negedge clk);
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        pending_vel.push_back(drag_update(v, rad, minv, dt));
        in_valid        = 1'b1;
        vel_x           = vx;
        vel_y           = vy;
        vel_z           = vz;
        particle_radius = rad;
        mass_inverse    = minv;
        time_step       = dt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [31:0] any_vel();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [30:0] any_u31();
        case ($urandom_range(0, 3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(0, 32'h0004_0000));
            2: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
            default: return 31'($urandom_range(0, 32'h0000_8000));
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_particle(any_vel(), any_vel(), any_vel(), any_u31(), any_u31(),
                any_u31());
    endtask

    task automatic test_reset_defaults();
        send_particle(32'h0001_0000, 32'hFFFF_0000, 32'h0, 31'h1_0000, 31'h1_0000,
            31'h1_0000);
        send_particle(32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
    endtask

    task automatic test_directed();
        set_drag(32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0002_0000,
            32'hFFFF_0000, 32'h0);
        send_particle(32'h0002_0000, 32'hFFFF_0000, 32'h0, 31'h1_0000,
            31'h1_0000, 31'h1_0000);
        send_particle(32'h0005_0000, 32'h0003_0000, 32'h0000_8000, 31'h0_8000,
            31'h2_0000, 31'h0_1000);
        send_particle(32'h0005_0000, 32'h0003_0000, 32'h0000_8000, 31'h7FFF_FFFF,
            31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h1_0000,
            31'h0_0100, 31'h0_0100);
        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
            31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_particle(32'h0, 32'h0, 32'h0, 31'h1_0000, 31'h0, 31'h1_0000);
        send_particle(32'hFFFF_FFFF, 32'h1, 32'h0, 31'h1_0000, 31'h1_0000,
            31'h0);
        set_drag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0,
            31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h1,
            31'h1, 31'h1);
        send_particle(32'h0, 32'h0, 32'h0, 31'h0_1000, 31'h0_0010, 31'h0_0010);
        wait (pending_vel.size() == 0);
        repeat (PIPE_LATENCY) @(negedge clk);
        write_reg(REG_RADIUS_OVERRIDE, 32'h0000_0001);
        send_particle(32'h0001_0000, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'h1_0000,
            31'h1_0000);
        wait (pending_vel.size() == 0);
        repeat (PIPE_LATENCY) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = 3'd7;
        cfg_data  = 32'hFFFF_FFFF;
        @(negedge clk);
        cfg_we = 1'b0;
        send_particle(32'h0003_0000, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000,
            31'h1_0000);
    endtask

    task automatic test_backpressure();
        set_drag(32'h0000_4000, 32'h0000_2000, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
        hold_sink = 1'b1;
        send_random(120);
        wait (!hold_sink);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++)
        begin
            set_drag($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0000_4000),
                p[0] ? $urandom_range(0, 32'h0002_0000) : 32'h0,
                any_vel(), any_vel(), any_vel());
            send_random(100);
        end
    endtask

    task automatic test_no_gaps();
        set_drag(32'h0001_8000, 32'h0000_1000, 32'h0, 32'h0, 32'h0, 32'hFFFE_0000);
        gaps_on = 1'b0;
        send_random(100);
    endtask

    always @(posedge clk)
        if (hold_sink)
        begin
            repeat (400) @(posedge clk);
            hold_sink <= 1'b0;
        end

    always @(negedge clk)
        if (!rst_n || hold_sink)
            out_ready <= 1'b0;
        else if (gaps_on && idle_cycles == 0 && $urandom_range(0, 7) == 0)
        begin
            idle_cycles = $urandom_range(1, 19);
            out_ready <= 1'b0;
        end
        else if (idle_cycles > 0)
        begin
            idle_cycles--;
            out_ready <= idle_cycles == 0;
        end
        else
            out_ready <= 1'b1;

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            velocity_t want;
            result_count++;
            if (pending_vel.size() == 0)
            begin
                $display("%0t: unexpected result %h %h %h", $time, new_vel_x,
                    new_vel_y, new_vel_z);
                error_count++;
            end
            else
            begin
                want = pending_vel.pop_front();
                if (new_vel_x !== want.vx)
                begin
                    $display("%0t: new_vel_x expected %h actual %h", $time, want.vx,
                        new_vel_x);
                    error_count++;
                end
                if (new_vel_y !== want.vy)
                begin
                    $display("%0t: new_vel_y expected %h actual %h", $time, want.vy,
                        new_vel_y);
                    error_count++;
                end
                if (new_vel_z !== want.vz)
                begin
                    $display("%0t: new_vel_z expected %h actual %h", $time, want.vz,
                        new_vel_z);
                    error_count++;
                end
            end
        end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else if (++quiet >= STALL_LIMIT)
            begin
                $display("tb_particle_fluid_drag_step failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        vel_x = '0;
        vel_y = '0;
        vel_z = '0;
        particle_radius = '0;
        mass_inverse = '0;
        time_step = '0;
        lin_coeff_q = '0;
        quad_coeff_q = '0;
        radius_ovr_q = '0;
        wind_q = '{default: '0};
        error_count = 0;
        sent_count = 0;
        result_count = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        hold_sink = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random_settings();
        test_no_gaps();
        wait (pending_vel.size() == 0);
        repeat (PIPE_LATENCY) @(negedge clk);
        $display("Sent %0d particles, checked %0d velocity updates across twelve",
            sent_count, result_count);
        $display("drag settings including saturated extremes and a long output stall.");
        if (error_count == 0)
            $display("tb_particle_fluid_drag_step passed");
        else
            $display("tb_particle_fluid_drag_step failed");
        $finish;
    end
endmodule
